>>> sv/cscm_pkg.sv
// shared types, constants and the per-entry firing rule of the schedule matcher
// no dependencies; used by cscm_mod_unit and calendar_schedule_matcher_top

package cscm_pkg;

  localparam int unsigned REG_COUNT   = 8;
  localparam int unsigned ENTRIES_DEF = 8;
  localparam int unsigned REG_W       = 9;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned VAL_W       = 6;
  localparam int unsigned MASK_W      = 8;

  localparam logic [VAL_W-1:0] POLL_WINDOW = VAL_W'(5);
  localparam logic [VAL_W:0]   HOUR_SLACK  = (VAL_W+1)'(2);

  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_SEC   = 3'd1;
  localparam logic [2:0] MODE_MIN   = 3'd2;
  localparam logic [2:0] MODE_HOUR  = 3'd3;
  localparam logic [2:0] MODE_DAY   = 3'd4;
  localparam logic [2:0] MODE_MONTH = 3'd5;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] mon;
  } tick_time_t;

  // request and response of the shared remainder unit
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [2:0] reg_mode(input logic [REG_W-1:0] r);
    return r[8:6];
  endfunction

  function automatic logic [VAL_W-1:0] reg_begin(input logic [REG_W-1:0] r);
    return r[5:0];
  endfunction

  // seconds and minutes modes with a nonzero begin value need a remainder
  function automatic logic needs_mod(input logic [REG_W-1:0] r);
    return ((reg_mode(r) == MODE_SEC) || (reg_mode(r) == MODE_MIN)) &&
           (reg_begin(r) != '0);
  endfunction

  // rem is only looked at where needs_mod holds
  function automatic logic entry_fires(input logic [REG_W-1:0] r,
                                       input tick_time_t       now,
                                       input tick_time_t       last,
                                       input logic [VAL_W-1:0] rem);
    logic [VAL_W-1:0] b;
    logic             nz;
    logic             f;
    b  = reg_begin(r);
    nz = (b != '0);
    f  = 1'b0;
    unique case (reg_mode(r))
      MODE_SEC: begin
        f = ((last.min != now.min) || (last.sec != now.sec)) &&
            ((now.sec == b) || (nz && (rem < POLL_WINDOW)));
      end
      MODE_MIN: begin
        f = ((last.hour != now.hour) || (last.min != now.min)) &&
            ((now.min == b) || (nz && (rem == '0)));
      end
      MODE_HOUR: begin
        f = (last.hour != now.hour) && (b >= now.min) &&
            ({1'b0, b} <= ({1'b0, now.min} + HOUR_SLACK));
      end
      MODE_DAY: begin
        f = (last.mday != now.mday) && (b == {1'b0, now.hour});
      end
      MODE_MONTH: begin
        f = (last.mon != now.mon) && (b == {1'b0, now.mday});
      end
      default: f = 1'b0;
    endcase
    return f;
  endfunction

endpackage

>>> sv/cscm_mod_unit.sv
// serial remainder unit, one restoring step per cycle
// depends on cscm_pkg for the request and response types

module cscm_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cscm_pkg::mod_req_t req_i,
  output cscm_pkg::mod_rsp_t rsp_o
);

  localparam int unsigned W     = cscm_pkg::VAL_W;
  localparam int unsigned CNT_W = $clog2(W);

  typedef enum logic {
    M_IDLE,
    M_RUN
  } mod_state_e;

  mod_state_e     state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]   dvd_q;
  logic [W-1:0]   div_q;
  logic [W-1:0]   rem_q;
  logic           done_q;

  logic [W:0]     trial;
  logic [W:0]     diff;
  logic [W-1:0]   rem_d;

  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign rem_d = (trial >= {1'b0, div_q}) ? diff[W-1:0] : trial[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            dvd_q   <= req_i.dividend;
            div_q   <= req_i.divisor;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= M_RUN;
          end
        end
        M_RUN: begin
          rem_q <= rem_d;
          dvd_q <= {dvd_q[W-2:0], 1'b0};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(W - 1)) begin
            done_q  <= 1'b1;
            state_q <= M_IDLE;
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> sv/calendar_schedule_matcher_top.sv
// calendar schedule matcher: sequencer, entry registers, last-fire store
// depends on cscm_pkg and cscm_mod_unit
//
// usage:
//   - the input channel (in_valid_i / in_ready_o) carries one poll tick as
//     broken-down local time: second, minute, hour, day of month, month
//   - each tick yields exactly one output transaction (out_valid_o /
//     out_ready_i) holding fire_mask, bit i set when entry i fired
//   - entries are to be written through cfg_we_i / cfg_idx_i / cfg_data_i only while
//     the block is idle, which the block does not enforce; an index of 8 or more is ignored
//   - the sequencer walks the entries one per step; an entry in seconds or
//     minutes mode with a nonzero begin value waits on the shared serial
//     remainder unit (one bit per cycle) after its evaluate step; every other
//     entry is settled in its evaluate step
//   - in_ready_o is high only in the idle state, so a new tick is accepted
//     only after the previous tick's mask has been loaded into the output register
//   - a stalled receiver holds the result in the output register; the next
//     tick can still be accepted and worked on, and its result waits until
//     the output register is free
//   - reset clears entries, the last-fire times (all fields zero) and any
//     pending result

module calendar_schedule_matcher_top #(
  parameter int unsigned ENTRIES = cscm_pkg::ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [cscm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cscm_pkg::REG_W-1:0]     cfg_data_i,
  // tick input
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [5:0]                     second_i,
  input  logic [5:0]                     minute_i,
  input  logic [4:0]                     hour_i,
  input  logic [4:0]                     day_of_month_i,
  input  logic [3:0]                     month_i,
  // result
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cscm_pkg::MASK_W-1:0]    fire_mask_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned REG_IDX_W = $clog2(cscm_pkg::REG_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_WAIT,
    S_OUT
  } seq_state_e;

  // entry registers, all eight stored whatever ENTRIES is
  logic [cscm_pkg::REG_W-1:0] entry_q [cscm_pkg::REG_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(cscm_pkg::REG_COUNT); i++) begin
        entry_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < cscm_pkg::CFG_IDX_W'(cscm_pkg::REG_COUNT))) begin
      entry_q[cfg_idx_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  seq_state_e                  state_q;
  logic [IDX_W-1:0]            idx_q;
  cscm_pkg::tick_time_t        now_q;
  cscm_pkg::tick_time_t        last_q [ENTRIES];
  logic [cscm_pkg::MASK_W-1:0] mask_q;
  logic                        out_valid_q;
  logic [cscm_pkg::MASK_W-1:0] fire_mask_q;

  cscm_pkg::mod_req_t mod_req;
  cscm_pkg::mod_rsp_t mod_rsp;

  logic [cscm_pkg::REG_W-1:0] cur_reg;
  cscm_pkg::tick_time_t       cur_last;
  logic                       cur_needs_mod;
  logic                       cur_fires;
  logic                       step_done;
  logic                       last_idx;
  logic [cscm_pkg::MASK_W-1:0] idx_bit;

  assign cur_reg       = entry_q[REG_IDX_W'(idx_q)];
  assign cur_last      = last_q[idx_q];
  assign cur_needs_mod = cscm_pkg::needs_mod(cur_reg);
  assign cur_fires     = cscm_pkg::entry_fires(cur_reg, now_q, cur_last, mod_rsp.rem);
  assign last_idx      = (idx_q == IDX_W'(ENTRIES - 1));
  assign idx_bit       = cscm_pkg::MASK_W'(1) << idx_q;

  // an entry is settled in the evaluate cycle, or when the remainder returns
  assign step_done = ((state_q == S_EVAL) && !cur_needs_mod) ||
                     ((state_q == S_WAIT) && mod_rsp.done);

  // seconds mode divides the second, minutes mode the minute
  assign mod_req.start    = (state_q == S_EVAL) && cur_needs_mod;
  assign mod_req.dividend = (cscm_pkg::reg_mode(cur_reg) == cscm_pkg::MODE_SEC) ?
                            now_q.sec : now_q.min;
  assign mod_req.divisor  = cscm_pkg::reg_begin(cur_reg);

  cscm_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(ENTRIES); i++) begin
        last_q[i] <= '0;
      end
    end else begin
      // the receiver takes the pending result
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            now_q.sec  <= second_i;
            now_q.min  <= minute_i;
            now_q.hour <= hour_i;
            now_q.mday <= day_of_month_i;
            now_q.mon  <= month_i;
            idx_q      <= '0;
            mask_q     <= '0;
            state_q    <= S_EVAL;
          end
        end
        S_EVAL, S_WAIT: begin
          if (mod_req.start) begin
            state_q <= S_WAIT;
          end else if (step_done) begin
            if (cur_fires) begin
              last_q[idx_q] <= now_q;
              mask_q        <= mask_q | idx_bit;
            end
            if (last_idx) begin
              state_q <= S_OUT;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= S_EVAL;
            end
          end
        end
        S_OUT: begin
          // load the output register once it is free or being emptied
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            fire_mask_q <= mask_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign fire_mask_o = fire_mask_q;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// testbench for calendar_schedule_matcher_top: directed and random poll ticks
// and entry settings, each fire mask checked against a scoreboard prediction
// depends on cscm_pkg and calendar_schedule_matcher_top

module testbench;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int NUM_ENTRIES  = 8;
  // watchdog limit on the whole run, covering tick work and receiver stalls
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 70;
  localparam int PHASES       = 8;
  localparam int PHASE_TICKS  = 75;

  // window of the seconds rule and reach of the hour rule
  localparam int POLL_SPAN  = 5;
  localparam int HOUR_REACH = 2;

  // mode code that no rule uses
  localparam logic [2:0] MODE_UNUSED = 3'd6;

  // config indexes past the end of the entry list
  localparam logic [cscm_pkg::CFG_IDX_W-1:0] CFG_IDX_PAST_END = 4'd8;
  localparam logic [cscm_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP      = 4'd15;

  // firing rule of one entry for one tick
  function automatic logic rule_hits(logic [cscm_pkg::REG_W-1:0] cfg,
                                     cscm_pkg::tick_time_t now,
                                     cscm_pkg::tick_time_t last);
    logic [2:0] m;
    int b;
    m = cfg[8:6];
    b = int'(cfg[5:0]);
    case (m)
      cscm_pkg::MODE_SEC:
        return ((last.min != now.min) || (last.sec != now.sec)) &&
               ((int'(now.sec) == b) || (b > 0 && (int'(now.sec) % b) < POLL_SPAN));
      cscm_pkg::MODE_MIN:
        return ((last.hour != now.hour) || (last.min != now.min)) &&
               ((int'(now.min) == b) || (b > 0 && (int'(now.min) % b) == 0));
      cscm_pkg::MODE_HOUR:
        return (last.hour != now.hour) && (b >= int'(now.min)) &&
               (b <= int'(now.min) + HOUR_REACH);
      cscm_pkg::MODE_DAY:
        return (last.mday != now.mday) && (b == int'(now.hour));
      cscm_pkg::MODE_MONTH:
        return (last.mon != now.mon) && (b == int'(now.mday));
      default:
        return 1'b0;
    endcase
  endfunction

  class fire_scoreboard;
    logic [cscm_pkg::REG_W-1:0]  entry_cfg[NUM_ENTRIES];
    cscm_pkg::tick_time_t        last_fire[NUM_ENTRIES];
    logic [cscm_pkg::MASK_W-1:0] pending_masks[$];
    int                          errors;

    function new();
      foreach (entry_cfg[i]) begin
        entry_cfg[i] = '0;
        last_fire[i] = '0;
      end
      errors = 0;
    endfunction

    function void write_entry(logic [cscm_pkg::CFG_IDX_W-1:0] idx,
                              logic [cscm_pkg::REG_W-1:0] data);
      if (idx < NUM_ENTRIES) entry_cfg[idx[2:0]] = data;
    endfunction

    // work out the fire mask of an accepted tick and update the last-fire times
    function void note_tick(cscm_pkg::tick_time_t now);
      logic [cscm_pkg::MASK_W-1:0] mask;
      mask = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (rule_hits(entry_cfg[i], now, last_fire[i])) begin
          last_fire[i] = now;
          mask[i]      = 1'b1;
        end
      end
      pending_masks.push_back(mask);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_mask(logic [cscm_pkg::MASK_W-1:0] got);
      logic [cscm_pkg::MASK_W-1:0] want;
      if (pending_masks.size() == 0) begin
        report_mismatch($sformatf("unexpected result fire_mask=%02h", got));
      end else begin
        want = pending_masks.pop_front();
        if (got !== want)
          report_mismatch($sformatf("fire_mask got %02h want %02h", got, want));
      end
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [cscm_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [cscm_pkg::REG_W-1:0]     cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [5:0]                     second_i;
  logic [5:0]                     minute_i;
  logic [4:0]                     hour_i;
  logic [4:0]                     day_of_month_i;
  logic [3:0]                     month_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [cscm_pkg::MASK_W-1:0]    fire_mask_o;

  fire_scoreboard       sb;
  int                   cycle_count = 0;
  bit                   tx_idle_on = 1'b1;
  bit                   rx_stall_on = 1'b1;
  cscm_pkg::tick_time_t wall_clock;
  cscm_pkg::tick_time_t last_sent;

  calendar_schedule_matcher_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .second_i       (second_i),
    .minute_i       (minute_i),
    .hour_i         (hour_i),
    .day_of_month_i (day_of_month_i),
    .month_i        (month_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .fire_mask_o    (fire_mask_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // monitor: register writes, accepted ticks and results, all sampled at the
  // rising edge; the result is checked before the tick of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_entry(cfg_idx_i, cfg_data_i);
      if (out_valid_o && out_ready_i) sb.check_mask(fire_mask_o);
      if (in_valid_i && in_ready_o)
        sb.note_tick('{sec: second_i, min: minute_i, hour: hour_i,
                       mday: day_of_month_i, mon: month_i});
    end
  end

  // receiver: ready drops in random bursts while stalls are on
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
        stall_left  = $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // one register write, enable held for a single cycle
  task automatic write_reg(logic [cscm_pkg::CFG_IDX_W-1:0] idx,
                           logic [cscm_pkg::REG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // offer one tick after an optional gap and hold it until accepted
  task automatic send_tick(cscm_pkg::tick_time_t t, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    second_i       <= t.sec;
    minute_i       <= t.min;
    hour_i         <= t.hour;
    day_of_month_i <= t.mday;
    month_i        <= t.mon;
    last_sent      = t;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering ticks and wait for every predicted mask to come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_masks.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic int pick_gap();
    if (tx_idle_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 15);
    return 0;
  endfunction

  // mode-aware random entry so that most settings can actually fire
  function automatic logic [cscm_pkg::REG_W-1:0] random_entry();
    logic [2:0] m;
    logic [5:0] b;
    if ($urandom_range(0, 9) < 8) m = 3'($urandom_range(1, 5));
    else m = 3'($urandom_range(0, 7));
    case (m)
      cscm_pkg::MODE_MIN:   b = 6'($urandom_range(0, 30));
      cscm_pkg::MODE_HOUR:  b = 6'($urandom_range(0, 61));
      cscm_pkg::MODE_DAY:   b = 6'($urandom_range(0, 23));
      cscm_pkg::MODE_MONTH: b = 6'($urandom_range(1, 31));
      default:              b = 6'($urandom_range(0, 63));
    endcase
    if ($urandom_range(0, 9) == 0) b = 6'($urandom_range(0, 63));
    return {m, b};
  endfunction

  // move the simulated wall clock forward, mostly by a few seconds
  function automatic cscm_pkg::tick_time_t advance_clock(cscm_pkg::tick_time_t t);
    int s, mi, h, d, mo, r;
    s  = t.sec;
    mi = t.min;
    h  = t.hour;
    d  = t.mday;
    mo = t.mon;
    r  = $urandom_range(0, 99);
    if (r < 60) s += $urandom_range(1, 8);
    else if (r < 80) mi += $urandom_range(1, 20);
    else if (r < 92) h += $urandom_range(1, 6);
    else if (r < 98) d += $urandom_range(1, 10);
    else mo += 1;
    if (s >= 60) begin
      s -= 60;
      mi++;
    end
    if (mi >= 60) begin
      mi -= 60;
      h++;
    end
    if (h >= 24) begin
      h -= 24;
      d++;
    end
    if (d > 31) begin
      d -= 31;
      mo++;
    end
    if (mo >= 12) mo -= 12;
    return '{sec: 6'(s), min: 6'(mi), hour: 5'(h), mday: 5'(d), mon: 4'(mo)};
  endfunction

  // mostly a clock that moves forward; some repeats, leap seconds and raw bits
  function automatic cscm_pkg::tick_time_t next_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return last_sent;
    if (r < 24)
      return '{sec: 6'($urandom), min: 6'($urandom), hour: 5'($urandom),
               mday: 5'($urandom), mon: 4'($urandom)};
    if (r < 30)
      return '{sec: 6'($urandom_range(0, 60)), min: 6'($urandom_range(0, 59)),
               hour: 5'($urandom_range(0, 23)), mday: 5'($urandom_range(1, 31)),
               mon: 4'($urandom_range(0, 11))};
    if (r < 32) begin
      wall_clock.sec = 6'd60;
      return wall_clock;
    end
    wall_clock = advance_clock(wall_clock);
    return wall_clock;
  endfunction

  // entry setting of one phase; the first three are fixed, the first of them extremes, the rest random
  task automatic apply_phase_setting(int phase);
    logic [cscm_pkg::REG_W-1:0] extremes[NUM_ENTRIES];
    logic [cscm_pkg::REG_W-1:0] val;
    extremes = '{ {cscm_pkg::MODE_SEC, 6'd1}, {cscm_pkg::MODE_SEC, 6'd63},
                  {cscm_pkg::MODE_MIN, 6'd1}, {cscm_pkg::MODE_MIN, 6'd63},
                  {cscm_pkg::MODE_HOUR, 6'd0}, {cscm_pkg::MODE_HOUR, 6'd63},
                  {cscm_pkg::MODE_DAY, 6'd0}, {cscm_pkg::MODE_MONTH, 6'd63} };
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      case (phase)
        0:       val = extremes[i];
        1:       val = (i % 2) ? 9'h1FF : {cscm_pkg::MODE_SEC, 6'd1};
        2:       val = (i % 2) ? 9'h000 : {cscm_pkg::MODE_MIN, 6'd1};
        default: val = random_entry();
      endcase
      write_reg(cscm_pkg::CFG_IDX_W'(i), val);
    end
    // writes past the end of the list must leave every entry alone
    write_reg(cscm_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_PAST_END, CFG_IDX_TOP)),
              cscm_pkg::REG_W'($urandom));
  endtask

  initial begin
    cscm_pkg::tick_time_t       directed[$];
    logic [cscm_pkg::REG_W-1:0] directed_cfg[NUM_ENTRIES];

    sb             = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    second_i       = '0;
    minute_i       = '0;
    hour_i         = '0;
    day_of_month_i = '0;
    month_i        = '0;
    wall_clock     = '{sec: 6'd0, min: 6'd0, hour: 5'd0, mday: 5'd1, mon: 4'd0};
    last_sent      = wall_clock;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setting: every entry in none mode, masks stay zero
    send_tick('{sec: 6'd0, min: 6'd1, hour: 5'd2, mday: 5'd3, mon: 4'd4}, 0);
    send_tick('{sec: 6'd63, min: 6'd63, hour: 5'd31, mday: 5'd31, mon: 4'd15}, 0);
    wait_drained();

    // directed setting: every mode, seconds and minutes twice, plus an unused mode code
    directed_cfg = '{ {cscm_pkg::MODE_SEC, 6'd0}, {cscm_pkg::MODE_SEC, 6'd7},
                      {cscm_pkg::MODE_MIN, 6'd0}, {cscm_pkg::MODE_MIN, 6'd15},
                      {cscm_pkg::MODE_HOUR, 6'd30}, {cscm_pkg::MODE_DAY, 6'd12},
                      {cscm_pkg::MODE_MONTH, 6'd15}, {MODE_UNUSED, 6'd63} };
    for (int i = 0; i < NUM_ENTRIES; i++)
      write_reg(cscm_pkg::CFG_IDX_W'(i), directed_cfg[i]);
    write_reg(CFG_IDX_PAST_END, 9'h1FF);
    write_reg(CFG_IDX_TOP, 9'h041);

    // seconds with zero begin vs never-fired zero time, same tick repeated,
    // remainder just inside and just outside the window, minutes multiples,
    // hour window edges, day and month changes, leap second, raw all-ones,
    // out-of-range zero day and month 13
    directed = '{
      '{sec: 6'd0,  min: 6'd0,  hour: 5'd0,  mday: 5'd1,  mon: 4'd0},
      '{sec: 6'd0,  min: 6'd1,  hour: 5'd0,  mday: 5'd1,  mon: 4'd0},
      '{sec: 6'd7,  min: 6'd1,  hour: 5'd0,  mday: 5'd1,  mon: 4'd0},
      '{sec: 6'd7,  min: 6'd1,  hour: 5'd0,  mday: 5'd1,  mon: 4'd0},
      '{sec: 6'd11, min: 6'd1,  hour: 5'd0,  mday: 5'd1,  mon: 4'd0},
      '{sec: 6'd12, min: 6'd1,  hour: 5'd0,  mday: 5'd1,  mon: 4'd0},
      '{sec: 6'd0,  min: 6'd15, hour: 5'd0,  mday: 5'd1,  mon: 4'd0},
      '{sec: 6'd0,  min: 6'd30, hour: 5'd0,  mday: 5'd1,  mon: 4'd0},
      '{sec: 6'd0,  min: 6'd28, hour: 5'd1,  mday: 5'd1,  mon: 4'd0},
      '{sec: 6'd0,  min: 6'd31, hour: 5'd2,  mday: 5'd1,  mon: 4'd0},
      '{sec: 6'd0,  min: 6'd0,  hour: 5'd12, mday: 5'd5,  mon: 4'd0},
      '{sec: 6'd0,  min: 6'd0,  hour: 5'd12, mday: 5'd15, mon: 4'd3},
      '{sec: 6'd60, min: 6'd59, hour: 5'd23, mday: 5'd31, mon: 4'd11},
      '{sec: 6'd63, min: 6'd63, hour: 5'd31, mday: 5'd31, mon: 4'd15},
      '{sec: 6'd0,  min: 6'd0,  hour: 5'd0,  mday: 5'd0,  mon: 4'd0},
      '{sec: 6'd4,  min: 6'd61, hour: 5'd2,  mday: 5'd12, mon: 4'd13}
    };
    foreach (directed[k]) send_tick(directed[k], pick_gap());

    // random phases, each under its own entry setting written while idle
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      apply_phase_setting(phase);
      if (phase == PHASES - 1) begin
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
      end
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // stretches without sender idling inside the earlier phases too
        if (phase < PHASES - 1 && n % 25 == 0) tx_idle_on = ($urandom_range(0, 3) != 0);
        send_tick(next_tick(), pick_gap());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending_masks.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_masks.size()));

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
